FILE: rtl/rgbfade_pkg.sv
// ----------------------------------------------------------------------------
// rgbfade_pkg
// Shared types, codes and reset values of the rgb555 level table fade engine.
// ----------------------------------------------------------------------------
package rgbfade_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [7:0]        TINT_RST   = 8'h48;
	localparam logic [7:0]        OFFSET_RST = 8'h90;
	localparam logic [7:0]        LIMIT_RST  = 8'hFF;
	localparam logic signed [4:0] RATE_RST   = 5'sd0;

	// configuration register indexes
	localparam logic [1:0] REG_TINT   = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;
	localparam logic [1:0] REG_RATE   = 2'd3;

	typedef enum logic [1:0] {
		OP_BUILD = 2'd0,
		OP_TICK  = 2'd1,
		OP_PIXEL = 2'd2,
		OP_HOLD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_FADING   = 2'd0,
		ST_AT_START = 2'd1,
		ST_AT_END   = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_out;
		logic [7:0]  shade;
		logic [1:0]  fade_status;
		logic [3:0]  fade_position;
	} out_item_t;

	// classified item held in the queue between front and back
	typedef struct packed {
		op_t         op;
		logic        zero;
		logic [15:0] pixel;
	} item_t;

endpackage

FILE: rtl/rgbfade_stream_if.sv
// ----------------------------------------------------------------------------
// rgbfade_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface rgbfade_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/rgbfade_ram.sv
// ----------------------------------------------------------------------------
// rgbfade_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rgbfade_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/rgbfade_front.sv
// ----------------------------------------------------------------------------
// rgbfade_front
// Accepts input transfers, classifies the op and queues items for the back end.
// ----------------------------------------------------------------------------
module rgbfade_front (
	input  logic                 clk,
	input  logic                 arst_n,
	rgbfade_stream_if.sink       in_ch,
	output rgbfade_pkg::item_t   q_item,
	output logic                 q_valid,
	input  logic                 q_pop
);

	localparam int QD = rgbfade_pkg::QUEUE_DEPTH;
	localparam int AW = (QD > 1) ? $clog2(QD) : 1;
	localparam int CW = $clog2(QD + 1);

	rgbfade_pkg::item_t slot_q [QD];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               push;
	rgbfade_pkg::item_t new_item;

	assign in_ch.ready = (count_q != CW'(QD));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != '0);
	assign q_item      = slot_q[rd_ptr_q];

	always_comb begin
		new_item.op    = rgbfade_pkg::op_t'(in_ch.payload.op);
		new_item.zero  = (in_ch.payload.pixel_in == 16'h0000);
		new_item.pixel = in_ch.payload.pixel_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

FILE: rtl/rgbfade_back.sv
// ----------------------------------------------------------------------------
// rgbfade_back
// Executes queued items: table build, position tick, pixel blend and hold.
// ----------------------------------------------------------------------------
module rgbfade_back #(
	parameter int TABLE_DEPTH = rgbfade_pkg::TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rgbfade_pkg::item_t   q_item,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  logic [7:0]           tint,
	input  logic [7:0]           lut_offset,
	input  logic [7:0]           lut_limit,
	input  logic signed [4:0]    fade_rate,
	rgbfade_stream_if.source     out_ch
);

	localparam int PW = $clog2(TABLE_DEPTH);
	localparam int SW = ((PW > 5) ? PW : 5) + 2;
	localparam logic [PW-1:0] LAST_IDX = PW'(TABLE_DEPTH - 1);

	typedef enum logic [1:0] {
		S_RUN,
		S_BUILD,
		S_TICK_RD,
		S_REPORT
	} state_t;

	state_t                 state_q;
	logic [PW-1:0]          pos_q;
	logic [PW-1:0]          last_q;
	logic signed [4:0]      rate_q;
	rgbfade_pkg::status_t   status_q;
	logic [7:0]             level_q;
	logic [15:0]            lt_q;
	logic [7:0]             lt_lvl_q;
	logic [7:0]             lt_tint_q;
	logic [PW-1:0]          idx_q;
	logic [7:0]             prev_q;
	logic                   out_valid_q;
	rgbfade_pkg::out_item_t out_data_q;

	logic                   coef_ok;
	logic                   out_free;
	logic                   load_out;
	logic                   ram_we;
	logic [PW-1:0]          ram_waddr;
	logic [7:0]             ram_wdata;
	logic [PW-1:0]          ram_raddr;
	logic [7:0]             ram_rdata;
	logic signed [SW-1:0]   pos_sum;
	logic                   tick_low;
	logic                   tick_high;
	logic [PW-1:0]          tick_pos;
	logic [8:0]             scale;
	logic [17:0]            rec_sum;
	logic [7:0]             next_lvl;
	logic                   build_done;
	logic signed [18:0]     coef_b;
	logic signed [25:0]     coef_a;
	logic [15:0]            pix_res;

	function automatic logic [4:0] blend(input logic [4:0] c, input logic signed [25:0] a,
			input logic signed [18:0] b);
		logic signed [25:0] v;
		v = a + $signed(26'({1'b0, c})) * $signed(26'(b));
		if (v < 0) begin
			blend = 5'd0;
		end else if (v[25:16] > 10'd31) begin
			blend = 5'd31;
		end else begin
			blend = v[20:16];
		end
	endfunction

	rgbfade_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign coef_ok  = (lt_lvl_q == level_q) && (lt_tint_q == tint);
	assign out_free = !out_valid_q || out_ch.ready;

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_data_q;

	// tick arithmetic
	assign pos_sum   = $signed(SW'(pos_q)) + SW'(rate_q);
	assign tick_low  = (pos_sum < 0);
	assign tick_high = !tick_low && (pos_sum > $signed(SW'(last_q)));
	always_comb begin
		if (tick_low) begin
			tick_pos = '0;
		end else if (tick_high) begin
			tick_pos = last_q;
		end else begin
			tick_pos = pos_sum[PW-1:0];
		end
	end

	// table recurrence
	assign scale      = 9'd256 - {1'b0, lut_offset};
	assign rec_sum    = {2'b00, lut_offset, 8'h00} + ({9'd0, scale} * {10'd0, prev_q});
	assign next_lvl   = rec_sum[15:8];
	assign build_done = (idx_q == LAST_IDX) || (prev_q >= lut_limit);

	// pixel blend
	assign coef_a = 26'({lt_q, 5'b00000});
	assign coef_b = 19'sd65536 - $signed({3'b000, lt_q}) - $signed({3'b000, level_q, 8'h00});
	always_comb begin
		if (q_item.zero || q_item.op != rgbfade_pkg::OP_PIXEL) begin
			pix_res = 16'h0000;
		end else begin
			pix_res = {q_item.pixel[15],
				blend(q_item.pixel[14:10], coef_a, coef_b),
				blend(q_item.pixel[9:5], coef_a, coef_b),
				blend(q_item.pixel[4:0], coef_a, coef_b)};
		end
	end

	always_comb begin
		q_pop     = 1'b0;
		load_out  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = 8'h00;
		ram_raddr = pos_q;
		unique case (state_q)
			S_RUN: begin
				if (q_valid) begin
					unique case (q_item.op)
						rgbfade_pkg::OP_BUILD: begin
							q_pop  = 1'b1;
							ram_we = 1'b1;
						end
						rgbfade_pkg::OP_TICK: begin
							q_pop     = 1'b1;
							ram_raddr = tick_pos;
						end
						rgbfade_pkg::OP_PIXEL, rgbfade_pkg::OP_HOLD: begin
							if (coef_ok && out_free) begin
								q_pop    = 1'b1;
								load_out = 1'b1;
							end
						end
					endcase
				end
			end
			S_BUILD: begin
				if (!build_done) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q + 1'b1;
					ram_wdata = next_lvl;
				end
			end
			S_TICK_RD: begin
			end
			S_REPORT: begin
				load_out = coef_ok && out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			pos_q       <= '0;
			last_q      <= '0;
			rate_q      <= '0;
			status_q    <= rgbfade_pkg::ST_FADING;
			level_q     <= 8'h00;
			lt_q        <= 16'h0000;
			lt_lvl_q    <= 8'h00;
			lt_tint_q   <= 8'h00;
			idx_q       <= '0;
			prev_q      <= 8'h00;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			lt_q      <= level_q * tint;
			lt_lvl_q  <= level_q;
			lt_tint_q <= tint;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_RUN: begin
					if (q_pop) begin
						unique case (q_item.op)
							rgbfade_pkg::OP_BUILD: begin
								idx_q   <= '0;
								prev_q  <= 8'h00;
								state_q <= S_BUILD;
							end
							rgbfade_pkg::OP_TICK: begin
								pos_q <= tick_pos;
								if (tick_low) begin
									rate_q   <= '0;
									status_q <= rgbfade_pkg::ST_AT_START;
								end else if (tick_high) begin
									rate_q   <= '0;
									status_q <= rgbfade_pkg::ST_AT_END;
								end
								state_q <= S_TICK_RD;
							end
							rgbfade_pkg::OP_PIXEL, rgbfade_pkg::OP_HOLD: begin
								out_data_q.pixel_out     <= pix_res;
								out_data_q.shade         <= lt_q[15:8];
								out_data_q.fade_status   <= status_q;
								out_data_q.fade_position <= 4'(pos_q);
							end
						endcase
					end
				end
				S_BUILD: begin
					if (build_done) begin
						last_q   <= idx_q;
						pos_q    <= '0;
						rate_q   <= fade_rate;
						status_q <= rgbfade_pkg::ST_FADING;
						level_q  <= 8'h00;
						state_q  <= S_REPORT;
					end else begin
						idx_q  <= idx_q + 1'b1;
						prev_q <= next_lvl;
					end
				end
				S_TICK_RD: begin
					level_q <= ram_rdata;
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (load_out) begin
						out_data_q.pixel_out     <= 16'h0000;
						out_data_q.shade         <= lt_q[15:8];
						out_data_q.fade_status   <= status_q;
						out_data_q.fade_position <= 4'(pos_q);
						state_q                  <= S_RUN;
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/rgb555_lut_fade_engine_top.sv
// ----------------------------------------------------------------------------
// rgb555_lut_fade_engine_top
// Fades rgb555 pixels toward a tint using a level table built on request.
//
//   channel   dir  payload                                   handshake
//   in_ch     in   op, pixel_in                              valid/ready
//   out_ch    out  pixel_out, shade, fade_status, position   valid/ready
//   cfg       in   cfg_index, cfg_wdata                      cfg_we
//
// pixel and hold ops: one per cycle while results are taken and the
// level*tint product register is current.
// tick: a table read, then the level*tint product register when the level
// changed. build: one table entry per cycle.
// a two-entry queue decouples input transfers from execution; the output
// register holds a result under stall. reset clears control, not the table.
// ----------------------------------------------------------------------------
module rgb555_lut_fade_engine_top #(
	parameter int TABLE_DEPTH = rgbfade_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	rgbfade_stream_if.sink   in_ch,
	rgbfade_stream_if.source out_ch,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_wdata
);

	logic [7:0]         tint_q;
	logic [7:0]         offset_q;
	logic [7:0]         limit_q;
	logic signed [4:0]  rate_q;
	rgbfade_pkg::item_t q_item;
	logic               q_valid;
	logic               q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_q   <= rgbfade_pkg::TINT_RST;
			offset_q <= rgbfade_pkg::OFFSET_RST;
			limit_q  <= rgbfade_pkg::LIMIT_RST;
			rate_q   <= rgbfade_pkg::RATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbfade_pkg::REG_TINT:   tint_q   <= cfg_wdata;
				rgbfade_pkg::REG_OFFSET: offset_q <= cfg_wdata;
				rgbfade_pkg::REG_LIMIT:  limit_q  <= cfg_wdata;
				rgbfade_pkg::REG_RATE:   rate_q   <= $signed(cfg_wdata[4:0]);
			endcase
		end
	end

	rgbfade_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	rgbfade_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_item     (q_item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.tint       (tint_q),
		.lut_offset (offset_q),
		.lut_limit  (limit_q),
		.fade_rate  (rate_q),
		.out_ch     (out_ch)
	);

endmodule
